### design/npd_pkg.sv
// Shared types and constants for the nearest-point-in-direction block.
`timescale 1ns / 1ps

package npd_pkg;

  localparam int CoordW = 16;           // signed Q8.8 coordinate
  localparam int DistW  = CoordW + 1;   // running best distance, all ones = none
  localparam int TolW   = 10;           // tie tolerance, unsigned Q2.8
  localparam int IdxW   = 10;           // reported point index
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [1:0] {
    DirLeft   = 2'd0,
    DirRight  = 2'd1,
    DirTop    = 2'd2,
    DirBottom = 2'd3
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDirection = 2'd0,
    CfgOrdered   = 2'd1,
    CfgReference = 2'd2,
    CfgTolerance = 2'd3
  } cfg_idx_e;

  // One classified point as it travels from front to back.
  typedef struct packed {
    logic signed [CoordW-1:0] coord;     // coordinate on the selected axis
    logic [CoordW-1:0]        distance;  // coord - reference, valid when dist_pos
    logic                     dist_pos;  // distance strictly positive
    logic                     keep_max;  // tie keeps largest coordinate
    logic                     ordered;   // stop at first point farther than best plus tolerance
    logic [TolW-1:0]          tol;
    logic                     last;
  } item_t;

endpackage

### design/nearest_point_in_direction_core.sv
// Top level of the nearest-point-in-direction search block.
`timescale 1ns / 1ps

// Usage
//   Input channel: one point per transfer (point_x_i, point_y_i, last_point_i),
//   accepted when in_valid_i is high and in_stall_o is low. last_point_i marks
//   the final point of a list.
//   Output channel: one result per list (found_o, point_index_o), presented
//   with out_valid_o and held until a cycle with out_stall_i low.
//   Config channel: cfg_index_i selects direction (0), ordered mode (1),
//   reference coordinate (2) or tie tolerance (3); cfg_ready_o is always high.
//   Write it only while no list is in flight.
// Timing
//   One point per cycle sustained while the queue is not full. A point enters
//   the 4-entry queue on its transfer edge, is examined by the back end at the
//   queue head, and for a list end the result register loads when it is popped.
//   The front classifies in the accept cycle; the back does one compare set
//   against the running best per cycle, unless a list end waits on the result.
// Stall and reset
//   While a result waits under out_stall_i, non-final points keep flowing; only
//   the next list end waits, and in_stall_o rises once the queue fills.
//   Reset clears config and control registers, empties the queue and the search.

module nearest_point_in_direction_core #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [npd_pkg::CoordW-1:0] point_x_i,
  input  logic signed [npd_pkg::CoordW-1:0] point_y_i,
  input  logic                              last_point_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [npd_pkg::IdxW-1:0]          point_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [npd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [npd_pkg::CfgDataW-1:0]      cfg_data_i
);

  npd_pkg::item_t item;
  npd_pkg::item_t head;
  logic           q_empty;
  logic           q_full;
  logic           q_push;
  logic           q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign q_push      = in_valid_i && !q_full;

  npd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .item_o       (item)
  );

  npd_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (item),
    .pop_i       (q_pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  npd_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (!q_empty),
    .pop_o         (q_pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .found_o       (found_o),
    .point_index_o (point_index_o)
  );

  // a miss always reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> point_index_o == '0)
    else $error("result without a hit carries a nonzero index");

  // a new result only appears after a list end left the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop && head.last))
    else $error("result raised without a list end");

  // a taken result with no list end behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(q_pop && head.last) |=> !out_valid_o)
    else $error("result repeated after transfer");

  // nothing is popped from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

endmodule

### design/npd_front.sv
// Front end: configuration registers, point intake and distance classification.
`timescale 1ns / 1ps

module npd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [npd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [npd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic signed [npd_pkg::CoordW-1:0] point_x_i,
  input  logic signed [npd_pkg::CoordW-1:0] point_y_i,
  input  logic                         last_point_i,
  output npd_pkg::item_t               item_o
);

  npd_pkg::dir_e                     dir_q, dir_d;
  logic                              ordered_q, ordered_d;
  logic signed [npd_pkg::CoordW-1:0] ref_q, ref_d;
  logic [npd_pkg::TolW-1:0]          tol_q, tol_d;

  logic signed [npd_pkg::CoordW-1:0] coord;
  logic signed [npd_pkg::DistW-1:0]  diff;

  always_comb begin
    dir_d     = dir_q;
    ordered_d = ordered_q;
    ref_d     = ref_q;
    tol_d     = tol_q;
    if (cfg_valid_i) begin
      case (npd_pkg::cfg_idx_e'(cfg_index_i))
        npd_pkg::CfgDirection: dir_d     = npd_pkg::dir_e'(cfg_data_i[1:0]);
        npd_pkg::CfgOrdered:   ordered_d = cfg_data_i[0];
        npd_pkg::CfgReference: ref_d     = cfg_data_i[npd_pkg::CoordW-1:0];
        npd_pkg::CfgTolerance: tol_d     = cfg_data_i[npd_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= npd_pkg::DirLeft;
      ordered_q <= 1'b0;
      ref_q     <= '0;
      tol_q     <= '0;
    end else begin
      dir_q     <= dir_d;
      ordered_q <= ordered_d;
      ref_q     <= ref_d;
      tol_q     <= tol_d;
    end
  end

  // axis select and signed distance, one bit wider than the coordinate
  always_comb begin
    coord = (dir_q inside {npd_pkg::DirTop, npd_pkg::DirBottom}) ? point_y_i : point_x_i;
    diff  = {coord[npd_pkg::CoordW-1], coord} - {ref_q[npd_pkg::CoordW-1], ref_q};

    item_o.coord    = coord;
    item_o.distance = diff[npd_pkg::CoordW-1:0];
    item_o.dist_pos = !diff[npd_pkg::DistW-1] && (diff != '0);
    item_o.keep_max = dir_q inside {npd_pkg::DirRight, npd_pkg::DirTop};
    item_o.ordered  = ordered_q;
    item_o.tol      = tol_q;
    item_o.last     = last_point_i;
  end

endmodule

### design/npd_queue.sv
// Small register FIFO that decouples the front end from the search back end.
`timescale 1ns / 1ps

module npd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  npd_pkg::item_t push_data_i,
  input  logic           pop_i,
  output npd_pkg::item_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  npd_pkg::item_t    mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/npd_back.sv
// Back end: running best search, list position count and result register.
`timescale 1ns / 1ps

module npd_back #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  npd_pkg::item_t              head_i,
  input  logic                        head_valid_i,
  output logic                        pop_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        found_o,
  output logic [npd_pkg::IdxW-1:0]    point_index_o
);

  localparam int PosW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);

  logic [npd_pkg::DistW-1:0]          best_dist_q, best_dist_d;
  logic signed [npd_pkg::CoordW-1:0]  best_coord_q, best_coord_d;
  logic [PosW-1:0]                    best_pos_q, best_pos_d;
  logic                               have_best_q, have_best_d;
  logic                               stopped_q, stopped_d;
  logic [CntW-1:0]                    count_q, count_d;
  logic                               out_valid_q, out_valid_d;
  logic                               found_q, found_d;
  logic [npd_pkg::IdxW-1:0]           index_q, index_d;

  logic                               in_range;
  logic [npd_pkg::DistW-1:0]          dist_ext;
  logic [npd_pkg::DistW-1:0]          excess;
  logic                               better_coord;
  logic [PosW+npd_pkg::IdxW-1:0]      pos_ext;

  // a list end can only retire when the result register is free or being taken
  assign pop_o = head_valid_i && (!head_i.last || !out_valid_q || !out_stall_i);

  always_comb begin
    in_range     = (count_q < CntW'(MAX_POINTS));
    dist_ext     = {1'b0, head_i.distance};
    excess       = dist_ext - best_dist_q;
    better_coord = head_i.keep_max ? (head_i.coord > best_coord_q)
                                   : (head_i.coord < best_coord_q);

    best_dist_d  = best_dist_q;
    best_coord_d = best_coord_q;
    best_pos_d   = best_pos_q;
    have_best_d  = have_best_q;
    stopped_d    = stopped_q;
    count_d      = count_q;
    found_d      = found_q;
    index_d      = index_q;
    pos_ext      = '0;
    out_valid_d  = out_valid_q && out_stall_i;

    if (pop_o) begin
      if (!stopped_q && in_range && head_i.dist_pos) begin
        if (!have_best_q || (dist_ext < best_dist_q)) begin
          best_dist_d  = dist_ext;
          best_coord_d = head_i.coord;
          best_pos_d   = count_q[PosW-1:0];
          have_best_d  = 1'b1;
        end else if (excess <= npd_pkg::DistW'(head_i.tol)) begin
          if (better_coord) begin
            best_coord_d = head_i.coord;
            best_pos_d   = count_q[PosW-1:0];
          end
        end else if (head_i.ordered) begin
          stopped_d = 1'b1;
        end
      end
      if (in_range) begin
        count_d = count_q + 1'b1;
      end

      if (head_i.last) begin
        pos_ext     = (PosW + npd_pkg::IdxW)'(best_pos_d);
        out_valid_d = 1'b1;
        found_d     = have_best_d;
        index_d     = have_best_d ? pos_ext[npd_pkg::IdxW-1:0] : '0;
        // back to the idle search state for the next list
        best_dist_d  = '1;
        best_coord_d = '0;
        best_pos_d   = '0;
        have_best_d  = 1'b0;
        stopped_d    = 1'b0;
        count_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q  <= '1;
      best_coord_q <= '0;
      best_pos_q   <= '0;
      have_best_q  <= 1'b0;
      stopped_q    <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      best_dist_q  <= best_dist_d;
      best_coord_q <= best_coord_d;
      best_pos_q   <= best_pos_d;
      have_best_q  <= have_best_d;
      stopped_q    <= stopped_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    index_q <= index_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign point_index_o = index_q;

endmodule
